/* design/byte_fifo_burst_feeder_macros.svh */
// Assertion macros used by the feeder's top module.
`ifndef BYTE_FIFO_BURST_FEEDER_MACROS_SVH
`define BYTE_FIFO_BURST_FEEDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BFBF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/bfbf_pkg.sv */
package bfbf_pkg;

    // Fixed field widths.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int OP_W    = 2;
    localparam int FILL_W  = 11;
    localparam int BURST_W = 6;

    // Largest burst per drain request.
    localparam logic [BURST_W-1:0] BURST_CAP = 6'd32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAIN = 2'd1;
    localparam logic [OP_W-1:0] OP_POP   = 2'd2;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_DRAIN     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POPPED    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_EMPTY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAUSED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              push;
        logic              flush;
        logic              load_left;
        logic              single;
        logic              issue;
        logic              imm_load;
        logic [KIND_W-1:0] kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic last_issue;
        logic can_issue;
        logic can_imm;
        logic pend;
    } t_status;

endpackage

/* design/byte_fifo_burst_feeder.sv */
// A push stores its byte and a flush empties the buffer, neither giving a result;
// a push into a full buffer stores nothing and instead gives an overflow result.
// A drain streams one byte per cycle while the output is not stalled, paced by the
// single read port of the byte RAM and its registered read.
// Synchronous active-low reset clears both pointers, the fill count and the output valid,
// and sets the burst limit to 32; the byte RAM is not cleared.
`include "byte_fifo_burst_feeder_macros.svh"

module byte_fifo_burst_feeder #(
    parameter int DEPTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bfbf_pkg::OP_W-1:0]     i_opcode,
    input  logic [bfbf_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_ready_level,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bfbf_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [bfbf_pkg::KIND_W-1:0]   o_kind,
    output logic                          o_last_of_burst,
    output logic [bfbf_pkg::FILL_W-1:0]   o_fill_level,
    output logic [bfbf_pkg::FILL_W-1:0]   o_free_space,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfbf_pkg::BURST_W-1:0]  i_cfg_data
);

    bfbf_pkg::t_cmd    w_cmd;
    bfbf_pkg::t_status w_status;

    // The limit register takes a word in any cycle.
    assign o_cfg_ready = 1'b1;

    bfbf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_opcode      (i_opcode),
        .i_ready_level (i_ready_level),
        .i_status      (w_status),
        .o_in_stall    (o_in_stall),
        .o_cmd         (w_cmd)
    );

    bfbf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_data_byte     (i_data_byte),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_kind          (o_kind),
        .o_last_of_burst (o_last_of_burst),
        .o_fill_level    (o_fill_level),
        .o_free_space    (o_free_space)
    );

    // A read is never started on an empty buffer.
    `BFBF_ASSERT_NOW(a_no_read_empty, i_clk, i_rst_n, w_cmd.issue, !w_status.empty, "read issued on empty buffer")
    // A byte is never stored into a full buffer.
    `BFBF_ASSERT_NOW(a_no_write_full, i_clk, i_rst_n, w_cmd.push, !w_status.full, "byte stored into full buffer")
    // Only drain bytes may leave a burst open.
    `BFBF_ASSERT_NOW(a_single_last, i_clk, i_rst_n, o_out_valid && (o_kind != bfbf_pkg::KIND_DRAIN), o_last_of_burst, "single result without last mark")
    // A started read holds off the input until its byte has moved on.
    `BFBF_ASSERT_NEXT(a_pend_blocks, i_clk, i_rst_n, w_cmd.issue, o_in_stall, "input taken while a read is in flight")

endmodule

/* design/bfbf_ram.sv */
module bfbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/bfbf_dpath.sv */
module bfbf_dpath #(
    parameter int DEPTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfbf_pkg::t_cmd                i_cmd,
    input  logic [bfbf_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_cfg_valid,
    input  logic [bfbf_pkg::BURST_W-1:0]  i_cfg_data,
    input  logic                          i_out_stall,
    output bfbf_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output logic [bfbf_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [bfbf_pkg::KIND_W-1:0]   o_kind,
    output logic                          o_last_of_burst,
    output logic [bfbf_pkg::FILL_W-1:0]   o_fill_level,
    output logic [bfbf_pkg::FILL_W-1:0]   o_free_space
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = (PW > bfbf_pkg::BURST_W) ? PW : bfbf_pkg::BURST_W;
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    logic [PW-1:0]                  r_wp, n_wp;
    logic [PW-1:0]                  r_rp, n_rp;
    logic [PW-1:0]                  r_fill, n_fill;
    logic [bfbf_pkg::BURST_W-1:0]   r_left, n_left;
    logic [bfbf_pkg::BURST_W-1:0]   r_burst_max;
    logic                           r_pend, n_pend;
    logic                           r_pend_last;
    logic [bfbf_pkg::KIND_W-1:0]    r_pend_kind;
    logic [PW-1:0]                  r_pend_fill;
    logic                           r_out_valid, n_out_valid;
    logic [bfbf_pkg::BYTE_W-1:0]    r_out_byte;
    logic [bfbf_pkg::KIND_W-1:0]    r_out_kind;
    logic                           r_out_last;
    logic [PW-1:0]                  r_out_fill;

    logic                           out_free;
    logic                           pend_move;
    logic [bfbf_pkg::BURST_W-1:0]   limit;
    logic [bfbf_pkg::BURST_W-1:0]   burst_len;
    logic [bfbf_pkg::BYTE_W-1:0]    rd_data;

    // The output register can load when it is empty or being taken.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pend_move = r_pend && out_free;

    // Clamp the burst limit to 1..32 and cut it to the current fill.
    always_comb begin
        if (r_burst_max == '0) begin
            limit = bfbf_pkg::BURST_W'(1);
        end else if (r_burst_max > bfbf_pkg::BURST_CAP) begin
            limit = bfbf_pkg::BURST_CAP;
        end else begin
            limit = r_burst_max;
        end
        if (CW'(r_fill) < CW'(limit)) begin
            burst_len = bfbf_pkg::BURST_W'(r_fill);
        end else begin
            burst_len = limit;
        end
    end

    // Pointer, fill and burst counter updates.
    always_comb begin
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_fill = r_fill;
        n_left = r_left;
        if (i_cmd.push) begin
            n_wp   = (r_wp == LAST_IDX) ? '0 : r_wp + PW'(1);
            n_fill = r_fill + PW'(1);
        end
        if (i_cmd.flush) begin
            n_wp   = '0;
            n_rp   = '0;
            n_fill = '0;
        end
        if (i_cmd.load_left) begin
            n_left = i_cmd.single ? bfbf_pkg::BURST_W'(1) : burst_len;
        end
        if (i_cmd.issue) begin
            n_rp   = (r_rp == LAST_IDX) ? '0 : r_rp + PW'(1);
            n_fill = r_fill - PW'(1);
            n_left = r_left - bfbf_pkg::BURST_W'(1);
        end
    end

    // A read in flight waits in the RAM's output register until the output loads.
    always_comb begin
        if (i_cmd.issue) begin
            n_pend = 1'b1;
        end else if (pend_move) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end
        if (pend_move || i_cmd.imm_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_fill      <= '0;
            r_left      <= '0;
            r_burst_max <= bfbf_pkg::BURST_CAP;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_burst_max <= i_cfg_data;
            end
        end
    end

    // Payload registers for the pending read and the output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_pend_last <= (r_left == bfbf_pkg::BURST_W'(1));
            r_pend_kind <= i_cmd.kind;
            r_pend_fill <= r_fill - PW'(1);
        end
        if (pend_move) begin
            r_out_byte <= rd_data;
            r_out_kind <= r_pend_kind;
            r_out_last <= r_pend_last;
            r_out_fill <= r_pend_fill;
        end else if (i_cmd.imm_load) begin
            r_out_byte <= '0;
            r_out_kind <= i_cmd.kind;
            r_out_last <= 1'b1;
            r_out_fill <= r_fill;
        end
    end

    bfbf_ram #(
        .WIDTH (bfbf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (r_wp),
        .i_wr_data (i_data_byte),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (r_rp),
        .o_rd_data (rd_data)
    );

    // Status toward the controller.
    always_comb begin
        o_status.empty      = (r_fill == '0);
        o_status.full       = (r_fill == LAST_IDX);
        o_status.last_issue = (r_left == bfbf_pkg::BURST_W'(1));
        o_status.can_issue  = !r_pend || out_free;
        o_status.can_imm    = out_free && !r_pend;
        o_status.pend       = r_pend;
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_kind          = r_out_kind;
    assign o_last_of_burst = r_out_last;
    assign o_fill_level    = bfbf_pkg::FILL_W'(r_out_fill);
    assign o_free_space    = bfbf_pkg::FILL_W'(LAST_IDX - r_out_fill);

endmodule

/* design/bfbf_ctrl.sv */
module bfbf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [bfbf_pkg::OP_W-1:0]   i_opcode,
    input  logic                        i_ready_level,
    input  bfbf_pkg::t_status           i_status,
    output logic                        o_in_stall,
    output bfbf_pkg::t_cmd              o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BURST,
        S_IMMED
    } t_state;

    t_state                        r_state, n_state;
    logic [bfbf_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic                          accept;

    // New words are taken only when idle with no read in flight.
    assign o_in_stall = (r_state != S_IDLE) || i_status.pend;
    assign accept     = i_in_valid && !o_in_stall;

    // Decode and sequencing.
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        bfbf_pkg::OP_PUSH: begin
                            if (i_status.full) begin
                                n_state = S_IMMED;
                                n_kind  = bfbf_pkg::KIND_OVERFLOW;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        bfbf_pkg::OP_DRAIN: begin
                            if (i_ready_level) begin
                                if (i_status.empty) begin
                                    n_state = S_IMMED;
                                    n_kind  = bfbf_pkg::KIND_PAUSED;
                                end else begin
                                    o_cmd.load_left = 1'b1;
                                    n_state         = S_BURST;
                                    n_kind          = bfbf_pkg::KIND_DRAIN;
                                end
                            end
                        end
                        bfbf_pkg::OP_POP: begin
                            if (i_status.empty) begin
                                n_state = S_IMMED;
                                n_kind  = bfbf_pkg::KIND_POP_EMPTY;
                            end else begin
                                o_cmd.load_left = 1'b1;
                                o_cmd.single    = 1'b1;
                                n_state         = S_BURST;
                                n_kind          = bfbf_pkg::KIND_POPPED;
                            end
                        end
                        bfbf_pkg::OP_FLUSH: begin
                            o_cmd.flush = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_BURST: begin
                if (i_status.can_issue) begin
                    o_cmd.issue = 1'b1;
                    if (i_status.last_issue) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IMMED: begin
                if (i_status.can_imm) begin
                    o_cmd.imm_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result kind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= bfbf_pkg::KIND_DRAIN;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule
